/* design/acb_pkg.sv */
// Shared constants, payload types and arithmetic helpers of the color blend pipeline.
`timescale 1ns / 1ps

package acb_pkg;

  // Channel format: CH_BITS fraction bits, all ones means 1.0.
  localparam int CH_BITS    = 12;
  localparam int CH_MAX     = (1 << CH_BITS) - 1;
  localparam int CH_ONE     = 1 << CH_BITS;
  localparam int HALF_TURN  = CH_ONE / 2;
  localparam int RGB_BITS   = 3 * CH_BITS;
  localparam int W_BITS     = CH_BITS + 1;

  // Threshold ratio register, Q12 with 0.4 after reset.
  localparam int RATIO_FRAC  = 12;
  localparam int RATIO_BITS  = RATIO_FRAC + 1;
  localparam logic [RATIO_BITS-1:0] RATIO_RESET = RATIO_BITS'(1638);
  localparam int PROD_BITS   = RATIO_BITS + CH_BITS;

  // Hue with one full circle of offset on either side stays unsigned.
  localparam int HW_BITS    = CH_BITS + 2;
  localparam int LERP_BITS  = 2 * CH_BITS + 2;
  localparam int HACC_BITS  = HW_BITS + W_BITS + 1;

  // Scaling by 1 - s * frac: the divisor is full scale of s times full scale of frac.
  localparam longint unsigned DEN = longint'(CH_MAX) * longint'(CH_ONE);
  localparam int M_BITS     = 2 * CH_BITS;
  localparam int NUM_BITS   = CH_BITS + M_BITS;
  localparam int Y_BITS     = NUM_BITS + 1 - CH_BITS;
  localparam int Q_BITS     = Y_BITS - CH_BITS;
  localparam int H6_BITS    = CH_BITS + 3;

  // Hue sector of the six-sector conversion.
  typedef enum logic [2:0] {
    SECT_RED_YEL = 3'd0,
    SECT_YEL_GRN = 3'd1,
    SECT_GRN_CYN = 3'd2,
    SECT_CYN_BLU = 3'd3,
    SECT_BLU_MAG = 3'd4,
    SECT_MAG_RED = 3'd5
  } sector_e;

  typedef struct packed {
    logic [CH_BITS-1:0] r;
    logic [CH_BITS-1:0] g;
    logic [CH_BITS-1:0] b;
  } rgb_t;

  // After the front stage: clamped weight, unwrapped hues, ratio products.
  typedef struct packed {
    rgb_t                           a_rgb;
    rgb_t                           b_rgb;
    logic [CH_BITS-1:0]             a_sat;
    logic [CH_BITS-1:0]             b_sat;
    logic [CH_BITS-1:0]             a_val;
    logic [CH_BITS-1:0]             b_val;
    logic [HW_BITS-1:0]             ha;
    logic [HW_BITS-1:0]             hb;
    logic [W_BITS-1:0]              w;
    logic [3:0][CH_BITS-1:0]        rat_x;
    logic [3:0][PROD_BITS-1:0]      rat_p;
  } s1_t;

  // After the blend stage.
  typedef struct packed {
    rgb_t               rgb;
    logic [CH_BITS-1:0] h;
    logic [CH_BITS-1:0] s;
    logic [CH_BITS-1:0] v;
    logic               use_hsv;
  } s2_t;

  // After sector split: the three scale factors of p, q and t.
  typedef struct packed {
    rgb_t              rgb;
    logic [CH_BITS-1:0] v;
    sector_e           sector;
    logic [M_BITS-1:0] m_p;
    logic [M_BITS-1:0] m_q;
    logic [M_BITS-1:0] m_t;
    logic              use_hsv;
  } s3_t;

  // After the value multiply.
  typedef struct packed {
    rgb_t                rgb;
    logic [CH_BITS-1:0]  v;
    sector_e             sector;
    logic [NUM_BITS-1:0] num_p;
    logic [NUM_BITS-1:0] num_q;
    logic [NUM_BITS-1:0] num_t;
    logic                use_hsv;
  } s4_t;

  // Saturate a value with two guard bits to the channel range.
  function automatic logic [CH_BITS-1:0] sat_ch(input logic [CH_BITS+1:0] v);
    if (v > (CH_BITS+2)'(CH_MAX)) begin
      return CH_BITS'(CH_MAX);
    end
    return v[CH_BITS-1:0];
  endfunction

  // Weighted blend a*w + b*(1-w), rounded half up and saturated.
  function automatic logic [CH_BITS-1:0] lerp_ch(input logic [CH_BITS-1:0] a,
                                                 input logic [CH_BITS-1:0] b,
                                                 input logic [W_BITS-1:0]  w);
    logic [LERP_BITS-1:0] acc;
    acc = LERP_BITS'(a) * LERP_BITS'(w)
        + LERP_BITS'(b) * LERP_BITS'(W_BITS'(CH_ONE) - w)
        + LERP_BITS'(HALF_TURN);
    return sat_ch(acc[LERP_BITS-1:CH_BITS]);
  endfunction

  // Hue blend; the result wraps modulo one full circle.
  function automatic logic [CH_BITS-1:0] lerp_hue(input logic [HW_BITS-1:0] ha,
                                                  input logic [HW_BITS-1:0] hb,
                                                  input logic [W_BITS-1:0]  w);
    logic [HACC_BITS-1:0] acc;
    acc = HACC_BITS'(ha) * HACC_BITS'(w)
        + HACC_BITS'(hb) * HACC_BITS'(W_BITS'(CH_ONE) - w)
        + HACC_BITS'(HALF_TURN);
    return acc[CH_BITS +: CH_BITS];
  endfunction

  // Rounded division by DEN: shift out the power of two, then divide by CH_MAX
  // as a shift with a remainder correction, since CH_MAX is one below CH_ONE.
  function automatic logic [CH_BITS-1:0] div_den(input logic [NUM_BITS-1:0] num);
    logic [NUM_BITS:0]   x;
    logic [Y_BITS-1:0]   y;
    logic [Q_BITS:0]     q;
    logic [CH_BITS+1:0]  r;
    x = {1'b0, num} + (NUM_BITS+1)'(DEN / 2);
    y = x[NUM_BITS:CH_BITS];
    q = (Q_BITS+1)'(y[Y_BITS-1:CH_BITS]);
    r = (CH_BITS+2)'(y[CH_BITS-1:0]) + (CH_BITS+2)'(y[Y_BITS-1:CH_BITS]);
    if (r >= (CH_BITS+2)'(CH_MAX)) begin
      r = r - (CH_BITS+2)'(CH_MAX);
      q = q + (Q_BITS+1)'(1);
    end
    if (r >= (CH_BITS+2)'(CH_MAX)) begin
      q = q + (Q_BITS+1)'(1);
    end
    if (q > (Q_BITS+1)'(CH_MAX)) begin
      return CH_BITS'(CH_MAX);
    end
    return q[CH_BITS-1:0];
  endfunction

endpackage

/* design/adaptive_rgb_hsv_color_blend_unit.sv */
// Blends two colors given in RGB and HSV, choosing RGB or HSV interpolation per item.
// Usage:
//   Input channel (in_valid_i / in_stall_o) carries both colors and the weight;
//   an item is taken at a clock edge with in_valid_i high and in_stall_o low.
//   Output channel (out_valid_o / out_stall_i) carries red, green, blue and
//   used_hsv; a result is taken at an edge with out_valid_o high and out_stall_i low.
//   The configuration channel (cfg_valid_i / cfg_ready_o) writes the threshold
//   ratio; cfg_ready_o is always high. Write it only while the pipeline is empty.
// Timing:
//   Five register stages: front, blend, sector, multiply, output. An accepted item
//   passes through them in that order. One item is taken every clock, limited only
//   by the output side.
// Reset:
//   All stage valid bits clear and the ratio returns to 0.4 (1638 in Q12).
// Stall:
//   While out_stall_i is high a valid output holds. Stages behind it keep
//   advancing into empty slots; in_stall_o rises only when every stage is full.
`timescale 1ns / 1ps

module adaptive_rgb_hsv_color_blend_unit (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [acb_pkg::RATIO_BITS-1:0] cfg_data_i,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [acb_pkg::RGB_BITS-1:0]   a_rgb_packed_i,
  input  logic [acb_pkg::CH_BITS-1:0]    a_hue_i,
  input  logic [acb_pkg::CH_BITS-1:0]    a_saturation_i,
  input  logic [acb_pkg::CH_BITS-1:0]    a_value_i,
  input  logic [acb_pkg::RGB_BITS-1:0]   b_rgb_packed_i,
  input  logic [acb_pkg::CH_BITS-1:0]    b_hue_i,
  input  logic [acb_pkg::CH_BITS-1:0]    b_saturation_i,
  input  logic [acb_pkg::CH_BITS-1:0]    b_value_i,
  input  logic [acb_pkg::W_BITS-1:0]     weight_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [acb_pkg::CH_BITS-1:0]    red_o,
  output logic [acb_pkg::CH_BITS-1:0]    green_o,
  output logic [acb_pkg::CH_BITS-1:0]    blue_o,
  output logic                           used_hsv_o
);

  logic [acb_pkg::RATIO_BITS-1:0] ratio_q;
  logic                           front_ready;
  logic                           s1_valid;
  logic                           s1_ready;
  acb_pkg::s1_t                   s1_data;
  logic                           s2_valid;
  logic                           s2_ready;
  acb_pkg::s2_t                   s2_data;
  logic                           s3_valid;
  logic                           s3_ready;
  acb_pkg::s3_t                   s3_data;
  logic                           s4_valid;
  logic                           s4_ready;
  acb_pkg::s4_t                   s4_data;
  logic                           out_valid_q;
  acb_pkg::rgb_t                  out_rgb_q;
  acb_pkg::rgb_t                  out_rgb_d;
  logic                           out_hsv_q;
  logic [acb_pkg::CH_BITS-1:0]    p;
  logic [acb_pkg::CH_BITS-1:0]    q;
  logic [acb_pkg::CH_BITS-1:0]    t;

  // Threshold ratio register.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ratio_q <= acb_pkg::RATIO_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      ratio_q <= cfg_data_i;
    end
  end

  assign in_stall_o = !front_ready;

  acb_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ratio_i  (ratio_q),
    .valid_i  (in_valid_i),
    .ready_o  (front_ready),
    .a_rgb_i  (a_rgb_packed_i),
    .a_hue_i  (a_hue_i),
    .a_sat_i  (a_saturation_i),
    .a_val_i  (a_value_i),
    .b_rgb_i  (b_rgb_packed_i),
    .b_hue_i  (b_hue_i),
    .b_sat_i  (b_saturation_i),
    .b_val_i  (b_value_i),
    .weight_i (weight_i),
    .valid_o  (s1_valid),
    .ready_i  (s1_ready),
    .data_o   (s1_data)
  );

  acb_lerp u_lerp (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s1_valid),
    .ready_o (s1_ready),
    .data_i  (s1_data),
    .valid_o (s2_valid),
    .ready_i (s2_ready),
    .data_o  (s2_data)
  );

  acb_hsv_prep u_hsv_prep (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s2_valid),
    .ready_o (s2_ready),
    .data_i  (s2_data),
    .valid_o (s3_valid),
    .ready_i (s3_ready),
    .data_o  (s3_data)
  );

  acb_hsv_scale u_hsv_scale (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s3_valid),
    .ready_o (s3_ready),
    .data_i  (s3_data),
    .valid_o (s4_valid),
    .ready_i (s4_ready),
    .data_o  (s4_data)
  );

  // Output stage: divide the products and route them by hue sector.
  assign s4_ready = !out_valid_q || !out_stall_i;

  always_comb begin
    p = acb_pkg::div_den(s4_data.num_p);
    q = acb_pkg::div_den(s4_data.num_q);
    t = acb_pkg::div_den(s4_data.num_t);
    if (s4_data.use_hsv) begin
      unique case (s4_data.sector)
        acb_pkg::SECT_RED_YEL: out_rgb_d = '{r: s4_data.v, g: t, b: p};
        acb_pkg::SECT_YEL_GRN: out_rgb_d = '{r: q, g: s4_data.v, b: p};
        acb_pkg::SECT_GRN_CYN: out_rgb_d = '{r: p, g: s4_data.v, b: t};
        acb_pkg::SECT_CYN_BLU: out_rgb_d = '{r: p, g: q, b: s4_data.v};
        acb_pkg::SECT_BLU_MAG: out_rgb_d = '{r: t, g: p, b: s4_data.v};
        default:               out_rgb_d = '{r: s4_data.v, g: p, b: q};
      endcase
    end else begin
      out_rgb_d = s4_data.rgb;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s4_ready) begin
      out_valid_q <= s4_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s4_ready && s4_valid) begin
      out_rgb_q <= out_rgb_d;
      out_hsv_q <= s4_data.use_hsv;
    end
  end

  assign out_valid_o = out_valid_q;
  assign red_o       = out_rgb_q.r;
  assign green_o     = out_rgb_q.g;
  assign blue_o      = out_rgb_q.b;
  assign used_hsv_o  = out_hsv_q;

endmodule

/* design/acb_front.sv */
// Front stage: weight clamp, hue unwrap and the ratio test products.
`timescale 1ns / 1ps

module acb_front (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic [acb_pkg::RATIO_BITS-1:0] ratio_i,
  input  logic                           valid_i,
  output logic                           ready_o,
  input  logic [acb_pkg::RGB_BITS-1:0]   a_rgb_i,
  input  logic [acb_pkg::CH_BITS-1:0]    a_hue_i,
  input  logic [acb_pkg::CH_BITS-1:0]    a_sat_i,
  input  logic [acb_pkg::CH_BITS-1:0]    a_val_i,
  input  logic [acb_pkg::RGB_BITS-1:0]   b_rgb_i,
  input  logic [acb_pkg::CH_BITS-1:0]    b_hue_i,
  input  logic [acb_pkg::CH_BITS-1:0]    b_sat_i,
  input  logic [acb_pkg::CH_BITS-1:0]    b_val_i,
  input  logic [acb_pkg::W_BITS-1:0]     weight_i,
  output logic                           valid_o,
  input  logic                           ready_i,
  output acb_pkg::s1_t                   data_o
);

  logic         valid_q;
  acb_pkg::s1_t data_q;
  acb_pkg::s1_t data_d;

  assign ready_o = !valid_q || ready_i;
  assign valid_o = valid_q;
  assign data_o  = data_q;

  // Clamp the weight, bring hue a within half a turn of hue b, form ratio products.
  always_comb begin
    data_d       = '0;
    data_d.a_rgb = a_rgb_i;
    data_d.b_rgb = b_rgb_i;
    data_d.a_sat = a_sat_i;
    data_d.b_sat = b_sat_i;
    data_d.a_val = a_val_i;
    data_d.b_val = b_val_i;

    if (weight_i > acb_pkg::W_BITS'(acb_pkg::CH_ONE)) begin
      data_d.w = acb_pkg::W_BITS'(acb_pkg::CH_ONE);
    end else begin
      data_d.w = weight_i;
    end

    data_d.hb = acb_pkg::HW_BITS'(b_hue_i) + acb_pkg::HW_BITS'(acb_pkg::CH_ONE);
    if (a_hue_i > b_hue_i &&
        (a_hue_i - b_hue_i) > acb_pkg::CH_BITS'(acb_pkg::HALF_TURN)) begin
      data_d.ha = acb_pkg::HW_BITS'(a_hue_i);
    end else if (b_hue_i > a_hue_i &&
                 (b_hue_i - a_hue_i) > acb_pkg::CH_BITS'(acb_pkg::HALF_TURN)) begin
      data_d.ha = acb_pkg::HW_BITS'(a_hue_i) + acb_pkg::HW_BITS'(2 * acb_pkg::CH_ONE);
    end else begin
      data_d.ha = acb_pkg::HW_BITS'(a_hue_i) + acb_pkg::HW_BITS'(acb_pkg::CH_ONE);
    end

    // Each test is x < ratio * y, with x compared after the next register.
    data_d.rat_x[0] = a_val_i;
    data_d.rat_p[0] = acb_pkg::PROD_BITS'(ratio_i) * acb_pkg::PROD_BITS'(b_val_i);
    data_d.rat_x[1] = b_val_i;
    data_d.rat_p[1] = acb_pkg::PROD_BITS'(ratio_i) * acb_pkg::PROD_BITS'(a_val_i);
    data_d.rat_x[2] = a_sat_i;
    data_d.rat_p[2] = acb_pkg::PROD_BITS'(ratio_i) * acb_pkg::PROD_BITS'(b_sat_i);
    data_d.rat_x[3] = b_sat_i;
    data_d.rat_p[3] = acb_pkg::PROD_BITS'(ratio_i) * acb_pkg::PROD_BITS'(a_sat_i);
  end

  // Stage valid bit.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  // Stage payload.
  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      data_q <= data_d;
    end
  end

endmodule

/* design/acb_lerp.sv */
// Blend stage: ratio decision and the weighted blends of RGB, hue, saturation and value.
`timescale 1ns / 1ps

module acb_lerp (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         valid_i,
  output logic         ready_o,
  input  acb_pkg::s1_t data_i,
  output logic         valid_o,
  input  logic         ready_i,
  output acb_pkg::s2_t data_o
);

  logic         valid_q;
  acb_pkg::s2_t data_q;
  acb_pkg::s2_t data_d;
  logic [3:0]   below;

  assign ready_o = !valid_q || ready_i;
  assign valid_o = valid_q;
  assign data_o  = data_q;

  // A mismatch in value or saturation in either direction selects RGB blending.
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      below[i] = acb_pkg::PROD_BITS'({data_i.rat_x[i], {acb_pkg::RATIO_FRAC{1'b0}}})
               < data_i.rat_p[i];
    end
  end

  // Blend every channel; the later stages pick RGB or HSV.
  always_comb begin
    data_d.rgb.r   = acb_pkg::lerp_ch(data_i.a_rgb.r, data_i.b_rgb.r, data_i.w);
    data_d.rgb.g   = acb_pkg::lerp_ch(data_i.a_rgb.g, data_i.b_rgb.g, data_i.w);
    data_d.rgb.b   = acb_pkg::lerp_ch(data_i.a_rgb.b, data_i.b_rgb.b, data_i.w);
    data_d.h       = acb_pkg::lerp_hue(data_i.ha, data_i.hb, data_i.w);
    data_d.s       = acb_pkg::lerp_ch(data_i.a_sat, data_i.b_sat, data_i.w);
    data_d.v       = acb_pkg::lerp_ch(data_i.a_val, data_i.b_val, data_i.w);
    data_d.use_hsv = ~|below;
  end

  // Stage valid bit.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  // Stage payload.
  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      data_q <= data_d;
    end
  end

endmodule

/* design/acb_hsv_prep.sv */
// Sector stage: hue sector, fraction and the three saturation scale factors.
`timescale 1ns / 1ps

module acb_hsv_prep (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         valid_i,
  output logic         ready_o,
  input  acb_pkg::s2_t data_i,
  output logic         valid_o,
  input  logic         ready_i,
  output acb_pkg::s3_t data_o
);

  logic                          valid_q;
  acb_pkg::s3_t                  data_q;
  acb_pkg::s3_t                  data_d;
  logic [acb_pkg::H6_BITS-1:0]   h6;
  logic [acb_pkg::CH_BITS-1:0]   frac;
  logic [acb_pkg::W_BITS-1:0]    frac_inv;
  logic [acb_pkg::M_BITS-1:0]    sf_q;
  logic [acb_pkg::M_BITS-1:0]    sf_t;

  assign ready_o = !valid_q || ready_i;
  assign valid_o = valid_q;
  assign data_o  = data_q;

  // Hue times six splits into the sector number and the position inside it.
  always_comb begin
    h6       = (acb_pkg::H6_BITS'(data_i.h) << 2) + (acb_pkg::H6_BITS'(data_i.h) << 1);
    frac     = h6[acb_pkg::CH_BITS-1:0];
    frac_inv = acb_pkg::W_BITS'(acb_pkg::CH_ONE) - acb_pkg::W_BITS'(frac);
    sf_q     = acb_pkg::M_BITS'(data_i.s) * acb_pkg::M_BITS'(frac);
    sf_t     = acb_pkg::M_BITS'(data_i.s) * acb_pkg::M_BITS'(frac_inv);
  end

  // Scale factors 1 - s, 1 - s*frac and 1 - s*(1-frac), in units of 1/DEN.
  always_comb begin
    data_d.rgb     = data_i.rgb;
    data_d.v       = data_i.v;
    data_d.sector  = acb_pkg::sector_e'(h6[acb_pkg::H6_BITS-1:acb_pkg::CH_BITS]);
    data_d.m_p     = acb_pkg::M_BITS'(acb_pkg::DEN)
                   - (acb_pkg::M_BITS'(data_i.s) << acb_pkg::CH_BITS);
    data_d.m_q     = acb_pkg::M_BITS'(acb_pkg::DEN) - sf_q;
    data_d.m_t     = acb_pkg::M_BITS'(acb_pkg::DEN) - sf_t;
    data_d.use_hsv = data_i.use_hsv;
  end

  // Stage valid bit.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  // Stage payload.
  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      data_q <= data_d;
    end
  end

endmodule

/* design/acb_hsv_scale.sv */
// Multiply stage: value times each of the three scale factors.
`timescale 1ns / 1ps

module acb_hsv_scale (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         valid_i,
  output logic         ready_o,
  input  acb_pkg::s3_t data_i,
  output logic         valid_o,
  input  logic         ready_i,
  output acb_pkg::s4_t data_o
);

  logic         valid_q;
  acb_pkg::s4_t data_q;
  acb_pkg::s4_t data_d;

  assign ready_o = !valid_q || ready_i;
  assign valid_o = valid_q;
  assign data_o  = data_q;

  // Three parallel value products, divided by DEN in the output stage.
  always_comb begin
    data_d.rgb     = data_i.rgb;
    data_d.v       = data_i.v;
    data_d.sector  = data_i.sector;
    data_d.num_p   = acb_pkg::NUM_BITS'(data_i.v) * acb_pkg::NUM_BITS'(data_i.m_p);
    data_d.num_q   = acb_pkg::NUM_BITS'(data_i.v) * acb_pkg::NUM_BITS'(data_i.m_q);
    data_d.num_t   = acb_pkg::NUM_BITS'(data_i.v) * acb_pkg::NUM_BITS'(data_i.m_t);
    data_d.use_hsv = data_i.use_hsv;
  end

  // Stage valid bit.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  // Stage payload.
  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      data_q <= data_d;
    end
  end

endmodule
